@@ hw/rtl/rafl_pkg.sv @@
// rafl_pkg: shared constants, types and the hash window function for the
// receive address filter loader; depends on nothing, used by every rtl file
package rafl_pkg;

	// exact filter slots, slot 0 is the station address
	localparam int EXACT_SLOTS = 128;
	localparam int SLOT_IDX_W  = $clog2(EXACT_SLOTS);
	localparam int SLOT_CNT_W  = $clog2(EXACT_SLOTS + 1);
	localparam int SLOT_OUT_W  = 7;

	// multicast hash table geometry
	localparam int HASH_WORDS  = 128;
	localparam int HASH_ADDR_W = $clog2(HASH_WORDS);
	localparam int WORD_W      = 32;
	localparam int BIT_SEL_W   = $clog2(WORD_W);
	localparam int HASH_W      = HASH_ADDR_W + BIT_SEL_W;

	// item fields
	localparam int OP_W    = 2;
	localparam int MAC_W   = 48;
	localparam int POOL_W  = 6;
	localparam int FTYPE_W = 2;
	localparam int CFG_W   = 8;

	// operation codes
	localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_W-1:0] OP_END   = 2'd2;

	// register indexes
	localparam logic CFG_FILTER_TYPE = 1'b0;
	localparam logic CFG_EXACT_SLOTS = 1'b1;

	// filter types
	localparam logic [FTYPE_W-1:0] FT_47_36 = 2'd0;
	localparam logic [FTYPE_W-1:0] FT_46_35 = 2'd1;
	localparam logic [FTYPE_W-1:0] FT_45_34 = 2'd2;

	// requests from the loader to the hash table
	typedef struct packed {
		logic                   clear;
		logic                   rd_en;
		logic [HASH_ADDR_W-1:0] rd_addr;
		logic                   wr_en;
		logic [HASH_ADDR_W-1:0] wr_addr;
		logic [WORD_W-1:0]      wr_data;
	} hash_req_t;

	// 12-bit hash bit index taken from the address
	function automatic logic [HASH_W-1:0] hash_bit_of(input logic [MAC_W-1:0] mac,
			input logic [FTYPE_W-1:0] ftype);
		logic [HASH_W-1:0] v;
		case (ftype)
			FT_47_36: v = mac[47:36];
			FT_46_35: v = mac[46:35];
			FT_45_34: v = mac[45:34];
			default:  v = mac[43:32];
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/rafl_hash_tbl.sv @@
// rafl_hash_tbl: multicast hash table, one synchronous memory with a registered
// read port and per-word valid flops so a clear needs no pass over the memory; uses rafl_pkg
module rafl_hash_tbl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rafl_pkg::hash_req_t        req,
	output logic [rafl_pkg::WORD_W-1:0] rd_data
);

	logic [rafl_pkg::WORD_W-1:0]     mem [rafl_pkg::HASH_WORDS];
	logic [rafl_pkg::WORD_W-1:0]     rd_data_q;
	logic [rafl_pkg::HASH_WORDS-1:0] vld_q;
	logic                            rd_vld_q;

	// memory array, write and registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	// word valid bits, a word never written since clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clear) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

@@ hw/rtl/rx_address_filter_loader.sv @@
// rx_address_filter_loader: top level, item sequencer, exact slot table and
// result registers; uses rafl_pkg and rafl_hash_tbl
//
// usage
// - an item (op, address, queue_index) is taken at a rising edge with start
//   high and busy low; busy stays high until the item's result is out
// - every item gives one result, shown for one cycle with done high; the
//   receiver cannot hold it off
// - begin, end and an add that takes an exact slot: the item goes to S_EXEC,
//   where its result is registered; the next item waits for S_IDLE
// - an add that goes to the hash table: one read-modify-write of the hash
//   memory, read in S_EXEC through the memory's registered read port, then
//   written back with the result registered in S_WB
// - begin clears the hash table through per-word valid flops and the exact
//   valid bits of slots 1 and up, so there is no clearing pass
// - reset: filter_type 0, exact_slots 128, next slot 1, no address hashed,
//   hash table all zero; the block is ready as soon as reset is released
// - configuration: cfg_we with cfg_index and cfg_data; the user must write it
//   only while the block is idle, which the block itself does not enforce
module rx_address_filter_loader (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [rafl_pkg::OP_W-1:0]          op,
	input  logic [rafl_pkg::MAC_W-1:0]         address,
	input  logic [rafl_pkg::POOL_W-1:0]        queue_index,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [rafl_pkg::CFG_W-1:0]         cfg_data,
	output logic                               done,
	output logic                               placed_exact,
	output logic [rafl_pkg::SLOT_OUT_W-1:0]    slot_index,
	output logic [rafl_pkg::HASH_W-1:0]        hash_vector,
	output logic [rafl_pkg::WORD_W-1:0]        hash_word,
	output logic                               mc_enable
);

	localparam int CMP_W = (rafl_pkg::SLOT_CNT_W > rafl_pkg::CFG_W) ?
		rafl_pkg::SLOT_CNT_W : rafl_pkg::CFG_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WB
	} state_t;

	state_t                            state_q;
	logic [rafl_pkg::FTYPE_W-1:0]      filter_type_q;
	logic [rafl_pkg::CFG_W-1:0]        exact_slots_q;
	logic [rafl_pkg::SLOT_CNT_W-1:0]   next_slot_q;
	logic                              any_hashed_q;
	logic [rafl_pkg::EXACT_SLOTS-1:0]  entry_valid_q;

	logic [rafl_pkg::OP_W-1:0]         op_s1;
	logic [rafl_pkg::MAC_W-1:0]        addr_s1;
	logic [rafl_pkg::POOL_W-1:0]       pool_s1;
	logic [rafl_pkg::HASH_W-1:0]       hvec_s1;

	logic                              done_q;
	logic                              placed_exact_q;
	logic [rafl_pkg::SLOT_OUT_W-1:0]   slot_index_q;
	logic [rafl_pkg::HASH_W-1:0]       hash_vector_q;
	logic [rafl_pkg::WORD_W-1:0]       hash_word_q;
	logic                              mc_enable_q;

	// exact entry memory, address and pool index side by side
	logic [rafl_pkg::MAC_W+rafl_pkg::POOL_W-1:0] entry_mem [rafl_pkg::EXACT_SLOTS];

	logic                              accept;
	logic                              exact_fit;
	logic [rafl_pkg::SLOT_IDX_W-1:0]   slot_addr;
	logic [rafl_pkg::WORD_W-1:0]       rd_word;
	logic [rafl_pkg::WORD_W-1:0]       new_word;
	rafl_pkg::hash_req_t               hreq;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// an add fits when the next slot is below both the register and the table size
	assign exact_fit = (CMP_W'(next_slot_q) < CMP_W'(exact_slots_q)) &&
		(CMP_W'(next_slot_q) < CMP_W'(rafl_pkg::EXACT_SLOTS));
	assign slot_addr = next_slot_q[rafl_pkg::SLOT_IDX_W-1:0];

	// hash word with the new bit set
	assign new_word = rd_word | (rafl_pkg::WORD_W'(1) << hvec_s1[rafl_pkg::BIT_SEL_W-1:0]);

	// hash table requests
	always_comb begin
		hreq.clear   = (state_q == S_EXEC) && (op_s1 == rafl_pkg::OP_BEGIN);
		hreq.rd_en   = (state_q == S_EXEC) && (op_s1 == rafl_pkg::OP_ADD) && !exact_fit;
		hreq.rd_addr = hvec_s1[rafl_pkg::HASH_W-1:rafl_pkg::BIT_SEL_W];
		hreq.wr_en   = (state_q == S_WB);
		hreq.wr_addr = hvec_s1[rafl_pkg::HASH_W-1:rafl_pkg::BIT_SEL_W];
		hreq.wr_data = new_word;
	end

	rafl_hash_tbl u_hash_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (hreq),
		.rd_data (rd_word)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_type_q <= '0;
			exact_slots_q <= rafl_pkg::CFG_W'(128);
		end else if (cfg_we) begin
			case (cfg_index)
				rafl_pkg::CFG_FILTER_TYPE: filter_type_q <= cfg_data[rafl_pkg::FTYPE_W-1:0];
				rafl_pkg::CFG_EXACT_SLOTS: exact_slots_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			addr_s1 <= address;
			pool_s1 <= queue_index;
			hvec_s1 <= rafl_pkg::hash_bit_of(address, filter_type_q);
		end
	end

	// exact slot contents
	always_ff @(posedge clk) begin
		if ((state_q == S_EXEC) && (op_s1 == rafl_pkg::OP_ADD) && exact_fit) begin
			entry_mem[slot_addr] <= {addr_s1, pool_s1};
		end
	end

	// sequencer, list state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			next_slot_q    <= rafl_pkg::SLOT_CNT_W'(1);
			any_hashed_q   <= 1'b0;
			entry_valid_q  <= '0;
			done_q         <= 1'b0;
			placed_exact_q <= 1'b0;
			slot_index_q   <= '0;
			hash_vector_q  <= '0;
			hash_word_q    <= '0;
			mc_enable_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					placed_exact_q <= 1'b0;
					slot_index_q   <= '0;
					hash_vector_q  <= '0;
					hash_word_q    <= '0;
					mc_enable_q    <= 1'b0;
					state_q        <= S_IDLE;
					done_q         <= 1'b1;
					case (op_s1)
						rafl_pkg::OP_BEGIN: begin
							entry_valid_q[rafl_pkg::EXACT_SLOTS-1:1] <= '0;
							next_slot_q  <= rafl_pkg::SLOT_CNT_W'(1);
							any_hashed_q <= 1'b0;
						end
						rafl_pkg::OP_ADD: begin
							if (exact_fit) begin
								entry_valid_q[slot_addr] <= 1'b1;
								next_slot_q    <= rafl_pkg::SLOT_CNT_W'(next_slot_q + 1'b1);
								placed_exact_q <= 1'b1;
								slot_index_q   <= rafl_pkg::SLOT_OUT_W'(next_slot_q);
							end else begin
								// hash word read is in flight
								state_q <= S_WB;
								done_q  <= 1'b0;
							end
						end
						rafl_pkg::OP_END: begin
							mc_enable_q <= any_hashed_q;
						end
						default: ;
					endcase
				end
				S_WB: begin
					any_hashed_q  <= 1'b1;
					hash_vector_q <= hvec_s1;
					hash_word_q   <= new_word;
					done_q        <= 1'b1;
					state_q       <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign placed_exact = placed_exact_q;
	assign slot_index   = slot_index_q;
	assign hash_vector  = hash_vector_q;
	assign hash_word    = hash_word_q;
	assign mc_enable    = mc_enable_q;

endmodule

@@ dv/tb.sv @@
// tb: self-checking testbench for rx_address_filter_loader
// needs rafl_pkg, rafl_hash_tbl and the rx_address_filter_loader rtl, nothing else
`timescale 1ns / 100ps

module tb;

	import rafl_pkg::*;

	// op code and filter type that the package leaves unnamed
	localparam logic [OP_W-1:0]    OP_UNUSED = 2'd3;
	localparam logic [FTYPE_W-1:0] FT_43_32  = 2'd3;

	// kinds of rows in the directed table
	localparam logic [1:0] ROW_CFG   = 2'd0;
	localparam logic [1:0] ROW_PRED  = 2'd1;
	localparam logic [1:0] ROW_FIXED = 2'd2;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEM_TARGET    = 920;

	typedef struct packed {
		logic                  placed;
		logic [SLOT_OUT_W-1:0] slot;
		logic [HASH_W-1:0]     hv;
		logic [WORD_W-1:0]     hw;
		logic                  mc;
	} filt_result_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              sel;
		logic [CFG_W-1:0]  val;
		logic [OP_W-1:0]   opc;
		logic [MAC_W-1:0]  mac;
		logic [POOL_W-1:0] pool;
		filt_result_t      want;
	} stim_row_t;

	localparam filt_result_t NO_RESULT = '0;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [OP_W-1:0]       op;
	logic [MAC_W-1:0]      address;
	logic [POOL_W-1:0]     queue_index;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  done;
	logic                  placed_exact;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic [HASH_W-1:0]     hash_vector;
	logic [WORD_W-1:0]     hash_word;
	logic                  mc_enable;

	// filter state as the testbench sees it
	logic [WORD_W-1:0] hash_mem [HASH_WORDS];
	logic [FTYPE_W-1:0] ftype_cfg;
	int                 slots_cfg;
	int                 next_free;
	logic               any_hashed;

	filt_result_t load_results_due [$];
	stim_row_t    stim_tab [32];

	int n_items;
	int n_exact;
	int n_hashed;
	int n_cfg;
	int n_errors;
	int gap_pct;
	int idle_cnt = 0;

	rx_address_filter_loader u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.address      (address),
		.queue_index  (queue_index),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.placed_exact (placed_exact),
		.slot_index   (slot_index),
		.hash_vector  (hash_vector),
		.hash_word    (hash_word),
		.mc_enable    (mc_enable)
	);

	always #2 clk = ~clk;

	// apply one list item to the filter state, return the result it gives
	function automatic filt_result_t load_filter_item(input logic [OP_W-1:0] o,
			input logic [MAC_W-1:0] a);
		filt_result_t r;
		int lim;
		int shamt;
		logic [HASH_W-1:0] v;
		logic [HASH_ADDR_W-1:0] w;
		r = '0;
		case (o)
			OP_BEGIN: begin
				foreach (hash_mem[i]) hash_mem[i] = '0;
				next_free  = 1;
				any_hashed = 1'b0;
			end
			OP_ADD: begin
				lim = (slots_cfg < EXACT_SLOTS) ? slots_cfg : EXACT_SLOTS;
				if (next_free < lim) begin
					r.placed = 1'b1;
					r.slot   = next_free[SLOT_OUT_W-1:0];
					next_free++;
					n_exact++;
				end else begin
					case (ftype_cfg)
						FT_47_36: shamt = 36;
						FT_46_35: shamt = 35;
						FT_45_34: shamt = 34;
						default:  shamt = 32;
					endcase
					v = HASH_W'(a >> shamt);
					w = v[HASH_W-1:BIT_SEL_W];
					hash_mem[w][v[BIT_SEL_W-1:0]] = 1'b1;
					any_hashed = 1'b1;
					r.hv = v;
					r.hw = hash_mem[w];
					n_hashed++;
				end
			end
			OP_END: r.mc = any_hashed;
			default: ;
		endcase
		return r;
	endfunction

	// random address, half the time with one of four fixed values in bits 47:32 so hash words fill up
	function automatic logic [MAC_W-1:0] rand_mac();
		logic [MAC_W-1:0] m;
		m = {16'($urandom), 32'($urandom)};
		case ($urandom_range(7))
			0: m[47:32] = 16'h0000;
			1: m[47:32] = 16'hFFFF;
			2: m[47:32] = 16'h8001;
			3: m[47:32] = 16'h7FFE;
			default: ;
		endcase
		return m;
	endfunction

	// drive one transaction, maybe after a gap, and log its expected result
	task automatic send_item(input logic [OP_W-1:0] o, input logic [MAC_W-1:0] a,
			input logic [POOL_W-1:0] q, input logic fixed, input filt_result_t fixed_want);
		filt_result_t r;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		start       <= 1'b1;
		op          <= o;
		address     <= a;
		queue_index <= q;
		do @(posedge clk); while (busy);
		r = load_filter_item(o, a);
		load_results_due.push_back(fixed ? fixed_want : r);
		if (o != OP_UNUSED)
			n_items++;
	endtask

	// register write once the loader has drained
	task automatic write_reg(input logic sel, input logic [CFG_W-1:0] val);
		start <= 1'b0;
		while (load_results_due.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (sel == CFG_FILTER_TYPE)
			ftype_cfg = val[FTYPE_W-1:0];
		else
			slots_cfg = int'(val);
		n_cfg++;
	endtask

	task automatic report(input string what, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		n_errors++;
		if (n_errors <= 10)
			$display("%0t: %s differs, expected 0x%0h got 0x%0h", $realtime, what, want, got);
	endtask

	// result checker, every done cycle is one transaction
	always @(posedge clk) begin
		filt_result_t want;
		if (arst_n && done) begin
			if (load_results_due.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("%0t: result with nothing outstanding", $realtime);
			end else begin
				want = load_results_due.pop_front();
				if (placed_exact !== want.placed)
					report("placed_exact", WORD_W'(want.placed), WORD_W'(placed_exact));
				if (slot_index !== want.slot)
					report("slot_index", WORD_W'(want.slot), WORD_W'(slot_index));
				if (hash_vector !== want.hv)
					report("hash_vector", WORD_W'(want.hv), WORD_W'(hash_vector));
				if (hash_word !== want.hw)
					report("hash_word", want.hw, hash_word);
				if (mc_enable !== want.mc)
					report("mc_enable", WORD_W'(want.mc), WORD_W'(mc_enable));
			end
		end
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int slot_tab [8];
		int idle_tab [4];
		int ph;
		int lim;
		int ph_first;
		int n_add;
		logic skip_begin;

		slot_tab = '{128, 1, 2, 0, 255, 5, 64, 17};
		idle_tab = '{0, 54, 0, 27};

		// directed table: extremes, every op, slot limits, every hash window
		stim_tab = '{
			'{ROW_FIXED, 1'b0, 8'd0, OP_END,    48'h0,            6'd0,  NO_RESULT},
			'{ROW_FIXED, 1'b0, 8'd0, OP_UNUSED, 48'hFFFFFFFFFFFF, 6'd63, NO_RESULT},
			'{ROW_FIXED, 1'b0, 8'd0, OP_BEGIN,  48'hFFFFFFFFFFFF, 6'd63, NO_RESULT},
			'{ROW_FIXED, 1'b0, 8'd0, OP_ADD,    48'h0,            6'd0,
				'{1'b1, 7'd1, 12'd0, 32'd0, 1'b0}},
			'{ROW_FIXED, 1'b0, 8'd0, OP_ADD,    48'hFFFFFFFFFFFF, 6'd63,
				'{1'b1, 7'd2, 12'd0, 32'd0, 1'b0}},
			'{ROW_FIXED, 1'b0, 8'd0, OP_END,    48'h0,            6'd0,  NO_RESULT},
			'{ROW_CFG, CFG_EXACT_SLOTS, 8'd2, OP_BEGIN, 48'h0, 6'd0, NO_RESULT},
			'{ROW_FIXED, 1'b0, 8'd0, OP_BEGIN,  48'h0,            6'd0,  NO_RESULT},
			'{ROW_FIXED, 1'b0, 8'd0, OP_ADD,    48'h123456789ABC, 6'd21,
				'{1'b1, 7'd1, 12'd0, 32'd0, 1'b0}},
			'{ROW_FIXED, 1'b0, 8'd0, OP_ADD,    48'hFFFFFFFFFFFF, 6'd42,
				'{1'b0, 7'd0, 12'hFFF, 32'h80000000, 1'b0}},
			'{ROW_FIXED, 1'b0, 8'd0, OP_ADD,    48'h0,            6'd0,
				'{1'b0, 7'd0, 12'd0, 32'd1, 1'b0}},
			'{ROW_PRED,  1'b0, 8'd0, OP_ADD,    48'h800000000000, 6'd5,  NO_RESULT},
			'{ROW_FIXED, 1'b0, 8'd0, OP_END,    48'h0,            6'd0,
				'{1'b0, 7'd0, 12'd0, 32'd0, 1'b1}},
			// add after end keeps the list going
			'{ROW_PRED,  1'b0, 8'd0, OP_ADD,    48'hFFE000000001, 6'd7,  NO_RESULT},
			'{ROW_CFG, CFG_FILTER_TYPE, 8'(FT_43_32), OP_BEGIN, 48'h0, 6'd0, NO_RESULT},
			'{ROW_PRED,  1'b0, 8'd0, OP_ADD,    48'h0F0F00000000, 6'd9,  NO_RESULT},
			'{ROW_CFG, CFG_FILTER_TYPE, 8'(FT_46_35), OP_BEGIN, 48'h0, 6'd0, NO_RESULT},
			'{ROW_PRED,  1'b0, 8'd0, OP_ADD,    48'h555555555555, 6'd10, NO_RESULT},
			'{ROW_CFG, CFG_FILTER_TYPE, 8'(FT_45_34), OP_BEGIN, 48'h0, 6'd0, NO_RESULT},
			'{ROW_PRED,  1'b0, 8'd0, OP_ADD,    48'hAAAAAAAAAAAA, 6'd11, NO_RESULT},
			// no usable slot, everything hashes
			'{ROW_CFG, CFG_EXACT_SLOTS, 8'd0, OP_BEGIN, 48'h0, 6'd0, NO_RESULT},
			'{ROW_FIXED, 1'b0, 8'd0, OP_BEGIN,  48'h0,            6'd0,  NO_RESULT},
			'{ROW_PRED,  1'b0, 8'd0, OP_ADD,    48'h0123456789AB, 6'd12, NO_RESULT},
			'{ROW_FIXED, 1'b0, 8'd0, OP_END,    48'h0,            6'd0,
				'{1'b0, 7'd0, 12'd0, 32'd0, 1'b1}},
			'{ROW_CFG, CFG_EXACT_SLOTS, 8'd1, OP_BEGIN, 48'h0, 6'd0, NO_RESULT},
			'{ROW_PRED,  1'b0, 8'd0, OP_ADD,    48'h00000000FFFF, 6'd13, NO_RESULT},
			// slot count above the slots present
			'{ROW_CFG, CFG_EXACT_SLOTS, 8'd255, OP_BEGIN, 48'h0, 6'd0, NO_RESULT},
			'{ROW_FIXED, 1'b0, 8'd0, OP_BEGIN,  48'h0,            6'd0,  NO_RESULT},
			'{ROW_PRED,  1'b0, 8'd0, OP_ADD,    48'h3C3C3C3C3C3C, 6'd14, NO_RESULT},
			'{ROW_CFG, CFG_EXACT_SLOTS, 8'd128, OP_BEGIN, 48'h0, 6'd0, NO_RESULT},
			'{ROW_CFG, CFG_FILTER_TYPE, 8'(FT_47_36), OP_BEGIN, 48'h0, 6'd0, NO_RESULT},
			'{ROW_FIXED, 1'b0, 8'd0, OP_END,    48'h0,            6'd0,  NO_RESULT}
		};

		// known values everywhere with reset held, then reset released
		arst_n      <= 1'b0;
		start       <= 1'b0;
		op          <= OP_BEGIN;
		address     <= '0;
		queue_index <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= CFG_FILTER_TYPE;
		cfg_data    <= '0;
		n_items     = 0;
		n_exact     = 0;
		n_hashed    = 0;
		n_cfg       = 0;
		n_errors    = 0;
		gap_pct     = 0;
		ftype_cfg   = FT_47_36;
		slots_cfg   = EXACT_SLOTS;
		next_free   = 1;
		any_hashed  = 1'b0;
		foreach (hash_mem[i]) hash_mem[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (stim_tab[i]) begin
			if (stim_tab[i].kind == ROW_CFG)
				write_reg(stim_tab[i].sel, stim_tab[i].val);
			else
				send_item(stim_tab[i].opc, stim_tab[i].mac, stim_tab[i].pool,
					stim_tab[i].kind == ROW_FIXED, stim_tab[i].want);
		end

		// random part: phases of settings and idling, mostly whole lists
		for (ph = 0; n_items < ITEM_TARGET; ph++) begin
			gap_pct = idle_tab[ph % 4];
			write_reg(CFG_FILTER_TYPE, 8'(ph % 4));
			write_reg(CFG_EXACT_SLOTS, 8'(slot_tab[ph % 8]));
			lim = (slot_tab[ph % 8] < EXACT_SLOTS) ? slot_tab[ph % 8] : EXACT_SLOTS;
			ph_first = n_items;
			skip_begin = $urandom_range(1);
			while (n_items - ph_first < 115 && n_items < ITEM_TARGET) begin
				if ($urandom_range(9) == 0) begin
					// stray item, any op
					send_item(2'($urandom_range(3)), rand_mac(), 6'($urandom_range(63)),
						1'b0, NO_RESULT);
				end else begin
					// a list; the first one may carry on from the previous slots
					if (!skip_begin)
						send_item(OP_BEGIN, rand_mac(), 6'($urandom_range(63)), 1'b0, NO_RESULT);
					if ($urandom_range(2) != 0)
						n_add = $urandom_range(lim + 3, 1);
					else
						n_add = lim + $urandom_range(12);
					repeat (n_add)
						send_item(OP_ADD, rand_mac(), 6'($urandom_range(63)), 1'b0, NO_RESULT);
					send_item(OP_END, rand_mac(), 6'($urandom_range(63)), 1'b0, NO_RESULT);
				end
				skip_begin = 1'b0;
			end
		end

		// drain and let the pipeline settle
		start <= 1'b0;
		while (load_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d transactions over %0d register writes", n_items, n_cfg);
		$display("adds: %0d into exact slots, %0d into the hash table", n_exact, n_hashed);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
